// ----- rtl/core/ccu_pkg.sv -----
`default_nettype none

package ccu_pkg;

    // Result and operand widths
    localparam int COUNT_W  = 63;
    localparam int FIELD_W  = 5;
    localparam int FACTOR_W = 6;
    localparam int GROUPS   = 4;

    // Default upper bound of population, chosen and group sizes
    localparam int MAX_POPULATION_DEF = 20;

    typedef logic [COUNT_W-1:0] count_t;

    // Count kinds
    localparam logic [1:0] OP_VARIATION   = 2'd0;
    localparam logic [1:0] OP_PERMUTATION = 2'd1;
    localparam logic [1:0] OP_COMBINATION = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;

    localparam count_t COUNT_MAX = '1;

endpackage

`default_nettype wire

// ----- rtl/core/ccu_wdiv.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle, full-width divisor.
// Dividend shifts out of the top of quo_reg while quotient bits shift in.
module ccu_wdiv (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire ccu_pkg::count_t dividend,
    input  wire ccu_pkg::count_t divisor,
    output logic                 done,
    output ccu_pkg::count_t      quotient
);

    localparam int CW    = ccu_pkg::COUNT_W;
    localparam int CNT_W = $clog2(CW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]    quo_reg, quo_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    dvs_reg, dvs_next;

    logic [CW:0]      trial;
    logic [CW:0]      diff;
    logic             fits;

    // One trial subtraction per cycle
    assign trial = {rem_reg, quo_reg[CW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[CW-1:0] : trial[CW-1:0];
            quo_next = {quo_reg[CW-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(CW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ccu_sdiv.sv -----
`default_nettype none

// Divider for a narrow divisor: one 4-bit digit of the dividend per cycle,
// four chained compare/subtract steps on a narrow remainder.
module ccu_sdiv (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire ccu_pkg::count_t            dividend,
    input  wire logic [ccu_pkg::FIELD_W-1:0] divisor,
    output logic                            done,
    output ccu_pkg::count_t                 quotient
);

    localparam int CW      = ccu_pkg::COUNT_W;
    localparam int FW      = ccu_pkg::FIELD_W;
    localparam int DIG_W   = 4;
    localparam int DIGITS  = (CW + DIG_W - 1) / DIG_W;
    localparam int SHIFT_W = DIGITS * DIG_W;
    localparam int CNT_W   = $clog2(DIGITS);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SHIFT_W-1:0] quo_reg, quo_next;
    logic [FW-1:0]      rem_reg, rem_next;
    logic [FW-1:0]      dvs_reg, dvs_next;

    logic [FW-1:0]      digit_rem;
    logic [DIG_W-1:0]   digit_quo;

    // One digit: restoring steps over its bits, top bit first
    always_comb
    begin
        logic [FW:0] t;
        logic [FW:0] d;
        digit_rem = rem_reg;
        digit_quo = '0;
        for (int j = 0; j < DIG_W; j++)
        begin
            t = {digit_rem, quo_reg[SHIFT_W-1-j]};
            d = t - {1'b0, dvs_reg};
            if (t >= {1'b0, dvs_reg})
            begin
                digit_rem              = d[FW-1:0];
                digit_quo[DIG_W-1-j]   = 1'b1;
            end
            else
            begin
                digit_rem = t[FW-1:0];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = SHIFT_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = digit_rem;
            quo_next = {quo_reg[SHIFT_W-DIG_W-1:0], digit_quo};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[CW-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/combinatorial_count_unit_top.sv -----
`default_nettype none

// Channel    Direction  Signals                                          Transaction
// ---------  ---------  -----------------------------------------------  ------------------------
// request    in         start, busy, op, with_repetition, population,    start high, busy low
//                       chosen, group_count, group_one..group_four
// result     out        done, count, status                              done high for one cycle
//
// Request time is set by the sequencer's one-factor-per-cycle multiply loop and the two serial
// dividers: out-of-range arguments finish straight from idle; power and falling factorials run
// the multiply loop; multinomial adds a group factorial and a wide division per group; combination
// does a multiply and a narrow division per step of min(k, m - k), m the upper binomial argument.
// Reset clears the sequencer and the result strobe; no stores need clearing.
// busy stays high until the result is issued. The receiver cannot stall: done is
// high for exactly one cycle.
module combinatorial_count_unit_top #(
    parameter int MAX_POPULATION = ccu_pkg::MAX_POPULATION_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  op,
    input  wire logic                        with_repetition,
    input  wire logic [ccu_pkg::FIELD_W-1:0] population,
    input  wire logic [ccu_pkg::FIELD_W-1:0] chosen,
    input  wire logic [2:0]                  group_count,
    input  wire logic [ccu_pkg::FIELD_W-1:0] group_one,
    input  wire logic [ccu_pkg::FIELD_W-1:0] group_two,
    input  wire logic [ccu_pkg::FIELD_W-1:0] group_three,
    input  wire logic [ccu_pkg::FIELD_W-1:0] group_four,
    output logic                             done,
    output logic [ccu_pkg::COUNT_W-1:0]      count,
    output logic [1:0]                       status
);

    localparam int CW  = ccu_pkg::COUNT_W;
    localparam int FW  = ccu_pkg::FIELD_W;
    localparam int FCW = ccu_pkg::FACTOR_W;
    localparam int PW  = CW + FCW;
    localparam int GN  = ccu_pkg::GROUPS;

    localparam logic [FW-1:0] MAX_POP = FW'(MAX_POPULATION);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_GMUL = 3'd2;
    localparam logic [2:0] S_GDIV = 3'd3;
    localparam logic [2:0] S_CMUL = 3'd4;
    localparam logic [2:0] S_CDIV = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic            pow_reg, pow_next;
    logic            multi_reg, multi_next;
    logic [2:0]      gc_reg, gc_next;
    logic [1:0]      gi_reg, gi_next;
    logic [FW-1:0]   grp_reg [GN];
    logic [FW-1:0]   grp_next [GN];
    logic [CW-1:0]   acc_reg, acc_next;
    logic [CW-1:0]   den_reg, den_next;
    logic [FCW-1:0]  fac_reg, fac_next;
    logic [FW-1:0]   rem_reg, rem_next;
    logic [FW-1:0]   step_reg, step_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [1:0]      status_reg, status_next;

    logic            n_bad, k_bad, gc_bad, g_bad;
    logic [FCW-1:0]  m_sum, m_minus_k;
    logic [FW-1:0]   kk;
    logic [CW-1:0]   mul_a;
    logic [PW-1:0]   prod;
    logic            ovf;

    logic            wdiv_start, wdiv_done;
    logic [CW-1:0]   wdiv_q;
    logic            sdiv_start, sdiv_done;
    logic [CW-1:0]   sdiv_q;

    // Argument range checks
    assign n_bad  = (population > MAX_POP);
    assign k_bad  = (chosen > MAX_POP);
    assign gc_bad = (group_count < 3'd2) || (group_count > 3'd4);
    assign g_bad  = (group_one > MAX_POP) || (group_two > MAX_POP)
                 || ((group_count >= 3'd3) && (group_three > MAX_POP))
                 || ((group_count == 3'd4) && (group_four > MAX_POP));

    // Binomial arguments: upper m and the smaller of k, m - k
    assign m_sum     = with_repetition ? (FCW'(population) + FCW'(chosen) - FCW'(1))
                                       : FCW'(population);
    assign m_minus_k = m_sum - FCW'(chosen);
    assign kk        = (FCW'(chosen) > m_minus_k) ? m_minus_k[FW-1:0] : chosen;

    // Shared multiplier: one factor per cycle while no divider is running
    assign mul_a = (state_reg == S_GMUL) ? den_reg : acc_reg;
    assign prod  = PW'(mul_a) * PW'(fac_reg);
    assign ovf   = |prod[PW-1:CW];

    // Sequencer
    always_comb
    begin
        logic          fin;
        logic [CW-1:0] fin_count;
        logic [1:0]    fin_status;

        fin        = 1'b0;
        fin_count  = '0;
        fin_status = ccu_pkg::STAT_OK;

        state_next  = state_reg;
        pow_next    = pow_reg;
        multi_next  = multi_reg;
        gc_next     = gc_reg;
        gi_next     = gi_reg;
        grp_next    = grp_reg;
        acc_next    = acc_reg;
        den_next    = den_reg;
        fac_next    = fac_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        count_next  = count_reg;
        status_next = status_reg;
        wdiv_start  = 1'b0;
        sdiv_start  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    gc_next     = group_count;
                    gi_next     = '0;
                    grp_next[0] = group_one;
                    grp_next[1] = group_two;
                    grp_next[2] = group_three;
                    grp_next[3] = group_four;
                    acc_next    = CW'(1);
                    step_next   = FW'(1);
                    pow_next    = 1'b0;
                    multi_next  = 1'b0;
                    unique case (op)
                        ccu_pkg::OP_VARIATION:
                        begin
                            if (n_bad || k_bad || (!with_repetition && (chosen > population)))
                            begin
                                fin        = 1'b1;
                                fin_status = ccu_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                fac_next   = FCW'(population);
                                rem_next   = chosen;
                                pow_next   = with_repetition;
                                state_next = S_MUL;
                            end
                        end
                        ccu_pkg::OP_PERMUTATION:
                        begin
                            if (with_repetition)
                            begin
                                if (n_bad || gc_bad || g_bad)
                                begin
                                    fin        = 1'b1;
                                    fin_status = ccu_pkg::STAT_RANGE;
                                end
                                else
                                begin
                                    fac_next   = FCW'(population);
                                    rem_next   = population;
                                    multi_next = 1'b1;
                                    state_next = S_MUL;
                                end
                            end
                            else if (k_bad)
                            begin
                                fin        = 1'b1;
                                fin_status = ccu_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                fac_next   = FCW'(chosen);
                                rem_next   = chosen;
                                state_next = S_MUL;
                            end
                        end
                        ccu_pkg::OP_COMBINATION:
                        begin
                            if (n_bad || k_bad || (!with_repetition && (chosen > population)))
                            begin
                                fin        = 1'b1;
                                fin_status = ccu_pkg::STAT_RANGE;
                            end
                            else if (with_repetition && (population == '0))
                            begin
                                // empty population: only the empty selection
                                fin       = 1'b1;
                                fin_count = (chosen == '0) ? CW'(1) : '0;
                            end
                            else
                            begin
                                fac_next   = m_sum;
                                rem_next   = kk;
                                state_next = S_CMUL;
                            end
                        end
                        default:
                        begin
                            fin        = 1'b1;
                            fin_status = ccu_pkg::STAT_RANGE;
                        end
                    endcase
                end
            end

            // Power or falling factorial into the accumulator
            S_MUL:
            begin
                if (rem_reg == '0)
                begin
                    if (multi_reg)
                    begin
                        den_next   = CW'(1);
                        fac_next   = FCW'(grp_reg[0]);
                        rem_next   = grp_reg[0];
                        for (int i = 0; i < GN - 1; i++)
                        begin
                            grp_next[i] = grp_reg[i+1];
                        end
                        state_next = S_GMUL;
                    end
                    else
                    begin
                        fin       = 1'b1;
                        fin_count = acc_reg;
                    end
                end
                else if (pow_reg && ovf)
                begin
                    fin        = 1'b1;
                    fin_count  = ccu_pkg::COUNT_MAX;
                    fin_status = ccu_pkg::STAT_SAT;
                end
                else
                begin
                    acc_next = prod[CW-1:0];
                    rem_next = rem_reg - FW'(1);
                    if (!pow_reg)
                    begin
                        fac_next = fac_reg - FCW'(1);
                    end
                end
            end

            // Group factorial into the divisor register
            S_GMUL:
            begin
                if (rem_reg == '0)
                begin
                    wdiv_start = 1'b1;
                    state_next = S_GDIV;
                end
                else
                begin
                    den_next = prod[CW-1:0];
                    fac_next = fac_reg - FCW'(1);
                    rem_next = rem_reg - FW'(1);
                end
            end

            // Divide by one group factorial; nested truncation equals one division
            S_GDIV:
            begin
                if (wdiv_done)
                begin
                    acc_next = wdiv_q;
                    if ((3'(gi_reg) + 3'd1) == gc_reg)
                    begin
                        fin       = 1'b1;
                        fin_count = wdiv_q;
                    end
                    else
                    begin
                        gi_next    = gi_reg + 2'd1;
                        den_next   = CW'(1);
                        fac_next   = FCW'(grp_reg[0]);
                        rem_next   = grp_reg[0];
                        for (int i = 0; i < GN - 1; i++)
                        begin
                            grp_next[i] = grp_reg[i+1];
                        end
                        state_next = S_GMUL;
                    end
                end
            end

            // Binomial step: multiply by (m - i), then exact divide by (i + 1)
            S_CMUL:
            begin
                if (rem_reg == '0)
                begin
                    fin       = 1'b1;
                    fin_count = acc_reg;
                end
                else
                begin
                    sdiv_start = 1'b1;
                    fac_next   = fac_reg - FCW'(1);
                    state_next = S_CDIV;
                end
            end

            S_CDIV:
            begin
                if (sdiv_done)
                begin
                    acc_next   = sdiv_q;
                    step_next  = step_reg + FW'(1);
                    rem_next   = rem_reg - FW'(1);
                    state_next = S_CMUL;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Issue the result
        if (fin)
        begin
            done_next   = 1'b1;
            count_next  = fin_count;
            status_next = fin_status;
            state_next  = S_IDLE;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pow_reg    <= pow_next;
        multi_reg  <= multi_next;
        gc_reg     <= gc_next;
        gi_reg     <= gi_next;
        grp_reg    <= grp_next;
        acc_reg    <= acc_next;
        den_reg    <= den_next;
        fac_reg    <= fac_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        count_reg  <= count_next;
        status_reg <= status_next;
    end

    // Wide divider for the multinomial
    ccu_wdiv u_wdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (wdiv_start),
        .dividend (acc_reg),
        .divisor  (den_reg),
        .done     (wdiv_done),
        .quotient (wdiv_q)
    );

    // Narrow divider for the binomial steps
    ccu_sdiv u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sdiv_start),
        .dividend (prod[CW-1:0]),
        .divisor  (step_reg),
        .done     (sdiv_done),
        .quotient (sdiv_q)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign count  = count_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

// ----- test/tb_combinatorial_count_unit_top.sv -----
`default_nettype none

module tb_combinatorial_count_unit_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW = ccu_pkg::FIELD_W;
    localparam int CW = ccu_pkg::COUNT_W;
    localparam int GN = ccu_pkg::GROUPS;

    // Kind code that the block must reject
    localparam logic [1:0] OP_UNDEFINED = 2'd3;
    localparam int unsigned MAX_POP = ccu_pkg::MAX_POPULATION_DEF;
    localparam longint unsigned COUNT_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int RANDOM_REQUESTS = 1250;
    // Cycle limit for the whole run, enforced by the watchdog
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic [1:0]              op;
        logic                    with_repetition;
        logic [FW-1:0]           population;
        logic [FW-1:0]           chosen;
        logic [2:0]              group_count;
        logic [GN-1:0][FW-1:0]   groups;
        bit                      drain_first;
    } count_request_t;

    typedef struct {
        ccu_pkg::count_t count;
        logic [1:0]      status;
    } count_answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] op = '0;
    logic with_repetition = 1'b0;
    logic [FW-1:0] population = '0;
    logic [FW-1:0] chosen = '0;
    logic [2:0] group_count = '0;
    logic [FW-1:0] group_one = '0;
    logic [FW-1:0] group_two = '0;
    logic [FW-1:0] group_three = '0;
    logic [FW-1:0] group_four = '0;
    logic done;
    logic [CW-1:0] count;
    logic [1:0] status;

    count_request_t pending_requests[$];
    count_answer_t  expected_answers[$];
    count_request_t current;

    int mismatches = 0;
    int requests_sent = 0;
    int requests_by_op[4] = '{0, 0, 0, 0};
    int answers_by_status[4] = '{0, 0, 0, 0};
    int cycle_count = 0;

    combinatorial_count_unit_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .with_repetition (with_repetition),
        .population      (population),
        .chosen          (chosen),
        .group_count     (group_count),
        .group_one       (group_one),
        .group_two       (group_two),
        .group_three     (group_three),
        .group_four      (group_four),
        .done            (done),
        .count           (count),
        .status          (status)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint unsigned factorial(input int unsigned v);
        longint unsigned acc;
        acc = 64'd1;
        for (int unsigned i = 2; i <= v; i++)
            acc *= 64'(i);
        return acc;
    endfunction

    // Exact binomial, running product stays well inside 64 bits for m < 40
    function automatic longint unsigned binomial(input int unsigned m, input int unsigned r);
        longint unsigned acc;
        int unsigned     steps;
        acc = 64'd1;
        steps = r;
        if (steps > m)
            return 64'd0;
        if (steps > m - steps)
            steps = m - steps;
        for (int unsigned i = 0; i < steps; i++)
            acc = acc * 64'(m - i) / 64'(i + 1);
        return acc;
    endfunction

    // Expected count and status for one request
    function automatic count_answer_t count_arrangements(input count_request_t rq);
        count_answer_t   ans;
        longint unsigned acc;
        longint unsigned whole;
        longint unsigned divisor;
        longint unsigned part;
        int unsigned     n;
        int unsigned     k;
        int unsigned     gc;
        bit              bad;
        bit              too_big;
        n = 32'(rq.population);
        k = 32'(rq.chosen);
        gc = 32'(rq.group_count);
        acc = 64'd0;
        ans.status = ccu_pkg::STAT_OK;
        case (rq.op) inside
            ccu_pkg::OP_VARIATION, ccu_pkg::OP_COMBINATION:
            begin
                if (n > MAX_POP || k > MAX_POP || (!rq.with_repetition && k > n))
                    ans.status = ccu_pkg::STAT_RANGE;
                else if (rq.op == ccu_pkg::OP_COMBINATION)
                begin
                    if (!rq.with_repetition)
                        acc = binomial(n, k);
                    else if (n == 0)
                        acc = (k == 0) ? 64'd1 : 64'd0;
                    else
                        acc = binomial(n + k - 1, k);
                end
                else if (!rq.with_repetition)
                    acc = factorial(n) / factorial(n - k);
                else
                begin
                    // power with saturation
                    acc = 64'd1;
                    for (int unsigned i = 0; i < k; i++)
                    begin
                        if (n != 0 && acc > COUNT_CAP / 64'(n))
                        begin
                            acc = COUNT_CAP;
                            ans.status = ccu_pkg::STAT_SAT;
                            break;
                        end
                        acc *= 64'(n);
                    end
                end
            end
            ccu_pkg::OP_PERMUTATION:
            begin
                if (!rq.with_repetition)
                begin
                    if (k > MAX_POP)
                        ans.status = ccu_pkg::STAT_RANGE;
                    else
                        acc = factorial(k);
                end
                else
                begin
                    bad = (n > MAX_POP || gc < 2 || gc > 4);
                    for (int unsigned i = 0; i < GN; i++)
                        if (i < gc && 32'(rq.groups[i]) > MAX_POP)
                            bad = 1'b1;
                    if (bad)
                        ans.status = ccu_pkg::STAT_RANGE;
                    else
                    begin
                        // group product beyond n! truncates the quotient to zero
                        whole = factorial(n);
                        divisor = 64'd1;
                        too_big = 1'b0;
                        for (int unsigned i = 0; i < gc; i++)
                        begin
                            part = factorial(32'(rq.groups[i]));
                            if (divisor > whole / part)
                            begin
                                too_big = 1'b1;
                                break;
                            end
                            divisor *= part;
                        end
                        acc = too_big ? 64'd0 : whole / divisor;
                    end
                end
            end
            default:
                ans.status = ccu_pkg::STAT_RANGE;
        endcase
        ans.count = acc[CW-1:0];
        return ans;
    endfunction

    function automatic count_request_t make_request(
        input logic [1:0] kind, input bit rep, input int unsigned n, input int unsigned k,
        input int unsigned gc, input int unsigned g1, input int unsigned g2,
        input int unsigned g3, input int unsigned g4);
        count_request_t rq;
        rq.op = kind;
        rq.with_repetition = rep;
        rq.population = n[FW-1:0];
        rq.chosen = k[FW-1:0];
        rq.group_count = gc[2:0];
        rq.groups[0] = g1[FW-1:0];
        rq.groups[1] = g2[FW-1:0];
        rq.groups[2] = g3[FW-1:0];
        rq.groups[3] = g4[FW-1:0];
        rq.drain_first = 1'b0;
        return rq;
    endfunction

    // Mostly well-formed requests with random content, about a tenth noise
    function automatic count_request_t random_request();
        count_request_t rq;
        int unsigned    left;
        int unsigned    part;
        int unsigned    n;
        int unsigned    gc;
        rq = make_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 7),
                          $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 31));
        if ($urandom_range(0, 99) < 10)
            return rq;
        rq.op = 2'($urandom_range(0, 2));
        rq.population = FW'($urandom_range(0, MAX_POP));
        n = 32'(rq.population);
        if (rq.op == ccu_pkg::OP_PERMUTATION)
        begin
            if (!rq.with_repetition)
                rq.chosen = FW'($urandom_range(0, MAX_POP));
            else
            begin
                rq.group_count = 3'($urandom_range(2, 4));
                gc = 32'(rq.group_count);
                left = n;
                for (int unsigned i = 0; i < GN; i++)
                begin
                    if (i >= gc)
                        continue;
                    if ($urandom_range(0, 3) == 0)
                        rq.groups[i] = FW'($urandom_range(0, MAX_POP));
                    else if (i == gc - 1 && $urandom_range(0, 1) != 0)
                        rq.groups[i] = FW'(left);
                    else
                    begin
                        part = $urandom_range(0, left);
                        rq.groups[i] = FW'(part);
                        left -= part;
                    end
                end
            end
        end
        else if (rq.with_repetition)
            rq.chosen = FW'($urandom_range(0, MAX_POP));
        else
            rq.chosen = FW'($urandom_range(0, n));
        return rq;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Driver: presents queued requests, predicts on each accepted transaction
    always @(posedge clk)
    begin
        bit taken;
        bit idle;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                expected_answers.push_back(count_arrangements(current));
                requests_sent++;
                requests_by_op[current.op]++;
            end
            // long quiet stretch with no idling in the middle of the run
            idle = (requests_sent < 300 || requests_sent >= 650)
                   && $urandom_range(0, 99) < 30;
            if (start && !taken)
            begin
                // hold the transaction until accepted
            end
            else if (pending_requests.size() != 0 && !idle
                     && !(pending_requests[0].drain_first && expected_answers.size() != 0))
            begin
                current = pending_requests.pop_front();
                op <= current.op;
                with_repetition <= current.with_repetition;
                population <= current.population;
                chosen <= current.chosen;
                group_count <= current.group_count;
                group_one <= current.groups[0];
                group_two <= current.groups[1];
                group_three <= current.groups[2];
                group_four <= current.groups[3];
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: checks each result strobe against the oldest prediction
    always @(posedge clk)
    begin
        count_answer_t want;
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
                report_mismatch($sformatf("result with none pending: count %0d status %0d",
                                          count, status));
            else
            begin
                want = expected_answers.pop_front();
                answers_by_status[status]++;
                if (count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d", count, want.count));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_answers.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        count_request_t rq;

        // directed corners
        pending_requests.push_back(make_request(ccu_pkg::OP_VARIATION, 1'b1, 0, 0, 2, 0, 0, 0, 0));
        pending_requests.push_back(make_request(ccu_pkg::OP_VARIATION, 1'b1, 0, 5, 2, 0, 0, 0, 0));
        pending_requests.push_back(make_request(ccu_pkg::OP_VARIATION, 1'b1, 20, 20, 2, 0, 0, 0,
                                                0));
        pending_requests.push_back(make_request(ccu_pkg::OP_VARIATION, 1'b1, 2, 20, 2, 0, 0, 0,
                                                0));
        pending_requests.push_back(make_request(ccu_pkg::OP_VARIATION, 1'b1, 31, 31, 7, 31, 31,
                                                31, 31));
        pending_requests.push_back(make_request(ccu_pkg::OP_VARIATION, 1'b0, 20, 20, 2, 0, 0, 0,
                                                0));
        pending_requests.push_back(make_request(ccu_pkg::OP_VARIATION, 1'b0, 5, 7, 2, 0, 0, 0, 0));
        pending_requests.push_back(make_request(ccu_pkg::OP_PERMUTATION, 1'b1, 20, 0, 4, 5, 5, 5,
                                                5));
        pending_requests.push_back(make_request(ccu_pkg::OP_PERMUTATION, 1'b1, 4, 31, 2, 20, 20,
                                                31, 31));
        pending_requests.push_back(make_request(ccu_pkg::OP_PERMUTATION, 1'b1, 10, 0, 1, 2, 2, 2,
                                                2));
        pending_requests.push_back(make_request(ccu_pkg::OP_PERMUTATION, 1'b1, 10, 0, 5, 2, 2, 2,
                                                2));
        pending_requests.push_back(make_request(ccu_pkg::OP_PERMUTATION, 1'b1, 10, 0, 7, 2, 2, 2,
                                                2));
        pending_requests.push_back(make_request(ccu_pkg::OP_PERMUTATION, 1'b1, 10, 0, 0, 2, 2, 2,
                                                2));
        pending_requests.push_back(make_request(ccu_pkg::OP_PERMUTATION, 1'b1, 10, 0, 3, 21, 0, 0,
                                                0));
        pending_requests.push_back(make_request(ccu_pkg::OP_PERMUTATION, 1'b1, 21, 0, 2, 1, 1, 0,
                                                0));
        pending_requests.push_back(make_request(ccu_pkg::OP_PERMUTATION, 1'b0, 31, 20, 0, 31, 31,
                                                31, 31));
        pending_requests.push_back(make_request(ccu_pkg::OP_PERMUTATION, 1'b0, 0, 21, 2, 0, 0, 0,
                                                0));
        pending_requests.push_back(make_request(ccu_pkg::OP_PERMUTATION, 1'b0, 0, 0, 2, 0, 0, 0,
                                                0));
        pending_requests.push_back(make_request(ccu_pkg::OP_COMBINATION, 1'b1, 0, 0, 2, 0, 0, 0,
                                                0));
        pending_requests.push_back(make_request(ccu_pkg::OP_COMBINATION, 1'b1, 0, 3, 2, 0, 0, 0,
                                                0));
        pending_requests.push_back(make_request(ccu_pkg::OP_COMBINATION, 1'b1, 20, 20, 2, 0, 0, 0,
                                                0));
        pending_requests.push_back(make_request(ccu_pkg::OP_COMBINATION, 1'b0, 20, 10, 2, 0, 0, 0,
                                                0));
        pending_requests.push_back(make_request(ccu_pkg::OP_COMBINATION, 1'b0, 3, 4, 2, 0, 0, 0,
                                                0));
        pending_requests.push_back(make_request(ccu_pkg::OP_COMBINATION, 1'b0, 31, 0, 2, 0, 0, 0,
                                                0));
        pending_requests.push_back(make_request(OP_UNDEFINED, 1'b1, 5, 5, 3, 1, 1, 1, 1));

        // random part, with a couple of full drains of the pipeline
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            rq = random_request();
            rq.drain_first = (i == 500 || i == 1000);
            pending_requests.push_back(rq);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || start)
            @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d variation, %0d permutation, %0d combination, %0d bad kind",
                 requests_sent, requests_by_op[0], requests_by_op[1], requests_by_op[2],
                 requests_by_op[3]);
        $display("Results seen: %0d ok, %0d out of range, %0d saturated; %0d mismatches",
                 answers_by_status[0], answers_by_status[1], answers_by_status[2], mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/ccu_pkg.sv
rtl/core/ccu_wdiv.sv
rtl/core/ccu_sdiv.sv
rtl/core/combinatorial_count_unit_top.sv
test/tb_combinatorial_count_unit_top.sv
